/* hw/rtl/etok_pkg.sv */
package etok_pkg;

  localparam int MAX_TOKEN_COUNT_DEF   = 256;
  localparam int MAX_TEXT_BYTES_DEF    = 1023;
  localparam int MAX_NUMBER_DIGITS_DEF = 127;

  // Result bundles waiting between the scanner and the output side.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // A byte can close a pending token, make one of its own and close the string.
  localparam int SLOTS  = 3;
  localparam int SLOT_W = 2;

  localparam logic [7:0] IDX_DROPPED = 8'hFF;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LC_C   = 8'h63;
  localparam logic [7:0] CH_LC_O   = 8'h6F;
  localparam logic [7:0] CH_LC_N   = 8'h6E;

  typedef enum logic [4:0] {
    K_LPAREN, K_RPAREN, K_CONC, K_POW, K_LSHIFT, K_RSHIFT, K_NUMBER,
    K_PLUS, K_MINUS, K_BITNOT, K_MUL, K_DIV, K_MOD, K_AND, K_OR, K_XOR, K_END
  } token_kind_t;

  typedef enum logic [1:0] {
    ST_OK, ST_BADCHAR, ST_DROPPED
  } status_t;

  typedef enum logic [3:0] {
    M_IDLE, M_NUM, M_STAR, M_LT, M_GT, M_C1, M_C2, M_C3, M_SKIP
  } scan_mode_t;

  typedef struct packed {
    token_kind_t kind;
    logic [31:0] value;
    logic [7:0]  index;
    status_t     status;
    logic        last;
  } result_t;

  typedef struct packed {
    result_t [SLOTS-1:0] slot;
    logic [SLOT_W-1:0]   count;
  } bundle_t;

endpackage

/* hw/rtl/etok_front.sv */
module etok_front #(
  parameter int MAX_TOKEN_COUNT   = etok_pkg::MAX_TOKEN_COUNT_DEF,
  parameter int MAX_TEXT_BYTES    = etok_pkg::MAX_TEXT_BYTES_DEF,
  parameter int MAX_NUMBER_DIGITS = etok_pkg::MAX_NUMBER_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              end_of_text,
  output logic              bundle_valid,
  output etok_pkg::bundle_t bundle
);

  localparam int TW = $clog2(MAX_TOKEN_COUNT + 1);
  localparam int BW = $clog2(MAX_TEXT_BYTES + 1);
  localparam int DW = $clog2(MAX_NUMBER_DIGITS + 1);
  localparam logic [TW-1:0] TOKEN_LIMIT = TW'(MAX_TOKEN_COUNT);
  localparam logic [BW-1:0] BYTE_LIMIT  = BW'(MAX_TEXT_BYTES);
  localparam logic [DW-1:0] DIGIT_LIMIT = DW'(MAX_NUMBER_DIGITS);
  localparam int NEV = 4;

  etok_pkg::scan_mode_t mode, mode_next;
  logic [31:0]   acc, acc_next;
  logic [DW-1:0] dcount, dcount_next;
  logic [TW-1:0] tokens, tokens_next;
  logic [BW-1:0] bytes, bytes_next;

  // Candidate events in model order: pending token completed by this byte,
  // token of the byte itself, pending token flushed at the end, then END.
  logic                  ev_v   [NEV];
  logic                  ev_err [NEV];
  etok_pkg::token_kind_t ev_kind[NEV];
  logic [31:0]           ev_val [NEV];

  always_comb begin
    logic                 active, finish, classify, digit, space, end_tok;
    logic [31:0]          dval;
    etok_pkg::scan_mode_t m;
    logic [TW-1:0]        te;
    logic [2:0]           n;
    etok_pkg::result_t    rec;
    etok_pkg::bundle_t    b;

    for (int k = 0; k < NEV; k++) begin
      ev_v[k]    = 1'b0;
      ev_err[k]  = 1'b0;
      ev_kind[k] = etok_pkg::K_END;
      ev_val[k]  = 32'd0;
    end
    m           = mode;
    acc_next    = acc;
    dcount_next = dcount;
    bytes_next  = bytes;
    classify    = 1'b0;
    end_tok     = 1'b0;
    finish      = end_of_text;
    digit       = (in_byte >= etok_pkg::CH_DIG0) && (in_byte <= etok_pkg::CH_DIG9);
    space       = (in_byte == etok_pkg::CH_SPACE) ||
                  ((in_byte >= etok_pkg::CH_TAB) && (in_byte <= etok_pkg::CH_CR));
    dval        = 32'(in_byte[3:0]);
    active      = (mode != etok_pkg::M_SKIP) && (bytes < BYTE_LIMIT);

    if (active) begin
      bytes_next = bytes + 1'b1;
      if (in_byte == etok_pkg::CH_NUL) begin
        finish = 1'b1;
      end else begin
        case (mode)
          etok_pkg::M_C1: begin
            if (in_byte == etok_pkg::CH_LC_O) m = etok_pkg::M_C2;
            else begin ev_v[0] = 1'b1; ev_err[0] = 1'b1; m = etok_pkg::M_SKIP; end
          end
          etok_pkg::M_C2: begin
            if (in_byte == etok_pkg::CH_LC_N) m = etok_pkg::M_C3;
            else begin ev_v[0] = 1'b1; ev_err[0] = 1'b1; m = etok_pkg::M_SKIP; end
          end
          etok_pkg::M_C3: begin
            if (in_byte == etok_pkg::CH_LC_C) begin
              ev_v[0] = 1'b1; ev_kind[0] = etok_pkg::K_CONC; m = etok_pkg::M_IDLE;
            end else begin
              ev_v[0] = 1'b1; ev_err[0] = 1'b1; m = etok_pkg::M_SKIP;
            end
          end
          etok_pkg::M_LT: begin
            if (in_byte == etok_pkg::CH_LT) begin
              ev_v[0] = 1'b1; ev_kind[0] = etok_pkg::K_LSHIFT; m = etok_pkg::M_IDLE;
            end else begin
              ev_v[0] = 1'b1; ev_err[0] = 1'b1; m = etok_pkg::M_SKIP;
            end
          end
          etok_pkg::M_GT: begin
            if (in_byte == etok_pkg::CH_GT) begin
              ev_v[0] = 1'b1; ev_kind[0] = etok_pkg::K_RSHIFT; m = etok_pkg::M_IDLE;
            end else begin
              ev_v[0] = 1'b1; ev_err[0] = 1'b1; m = etok_pkg::M_SKIP;
            end
          end
          etok_pkg::M_STAR: begin
            ev_v[0] = 1'b1;
            m       = etok_pkg::M_IDLE;
            if (in_byte == etok_pkg::CH_STAR) ev_kind[0] = etok_pkg::K_POW;
            else begin ev_kind[0] = etok_pkg::K_MUL; classify = 1'b1; end
          end
          etok_pkg::M_NUM: begin
            if (digit) begin
              if (dcount < DIGIT_LIMIT) begin
                acc_next    = (acc << 3) + (acc << 1) + dval;
                dcount_next = dcount + 1'b1;
              end
            end else begin
              ev_v[0]    = 1'b1;
              ev_kind[0] = etok_pkg::K_NUMBER;
              ev_val[0]  = acc;
              m          = etok_pkg::M_IDLE;
              classify   = 1'b1;
            end
          end
          etok_pkg::M_IDLE: classify = 1'b1;
          default: ;
        endcase

        if (classify && !space) begin
          if (digit) begin
            acc_next    = dval;
            dcount_next = DW'(1);
            m           = etok_pkg::M_NUM;
          end else begin
            case (in_byte)
              etok_pkg::CH_LPAREN: begin ev_v[1] = 1'b1; ev_kind[1] = etok_pkg::K_LPAREN; end
              etok_pkg::CH_RPAREN: begin ev_v[1] = 1'b1; ev_kind[1] = etok_pkg::K_RPAREN; end
              etok_pkg::CH_PLUS:   begin ev_v[1] = 1'b1; ev_kind[1] = etok_pkg::K_PLUS;   end
              etok_pkg::CH_MINUS:  begin ev_v[1] = 1'b1; ev_kind[1] = etok_pkg::K_MINUS;  end
              etok_pkg::CH_TILDE:  begin ev_v[1] = 1'b1; ev_kind[1] = etok_pkg::K_BITNOT; end
              etok_pkg::CH_SLASH:  begin ev_v[1] = 1'b1; ev_kind[1] = etok_pkg::K_DIV;    end
              etok_pkg::CH_PCT:    begin ev_v[1] = 1'b1; ev_kind[1] = etok_pkg::K_MOD;    end
              etok_pkg::CH_AMP:    begin ev_v[1] = 1'b1; ev_kind[1] = etok_pkg::K_AND;    end
              etok_pkg::CH_BAR:    begin ev_v[1] = 1'b1; ev_kind[1] = etok_pkg::K_OR;     end
              etok_pkg::CH_CARET:  begin ev_v[1] = 1'b1; ev_kind[1] = etok_pkg::K_XOR;    end
              etok_pkg::CH_LC_C:   m = etok_pkg::M_C1;
              etok_pkg::CH_STAR:   m = etok_pkg::M_STAR;
              etok_pkg::CH_LT:     m = etok_pkg::M_LT;
              etok_pkg::CH_GT:     m = etok_pkg::M_GT;
              default: begin ev_v[1] = 1'b1; ev_err[1] = 1'b1; m = etok_pkg::M_SKIP; end
            endcase
          end
        end
      end
    end

    // Close the string: complete whatever is pending, then END unless that is an error.
    if (finish && (m != etok_pkg::M_SKIP)) begin
      case (m)
        etok_pkg::M_NUM: begin
          ev_v[2] = 1'b1; ev_kind[2] = etok_pkg::K_NUMBER; ev_val[2] = acc_next;
        end
        etok_pkg::M_STAR: begin
          ev_v[2] = 1'b1; ev_kind[2] = etok_pkg::K_MUL;
        end
        etok_pkg::M_LT, etok_pkg::M_GT, etok_pkg::M_C1, etok_pkg::M_C2,
        etok_pkg::M_C3: begin
          ev_v[2] = 1'b1; ev_err[2] = 1'b1;
        end
        default: ;
      endcase
      if (!ev_err[2]) begin
        ev_v[3] = 1'b1; ev_kind[3] = etok_pkg::K_END; end_tok = 1'b1;
      end
      m = etok_pkg::M_SKIP;
    end

    // Number the events and keep the first three.
    te  = tokens;
    n   = 3'd0;
    b   = '0;
    rec = '0;
    for (int k = 0; k < NEV; k++) begin
      if (ev_v[k]) begin
        rec.kind  = ev_kind[k];
        rec.value = ev_val[k];
        rec.last  = 1'b0;
        if (ev_err[k]) begin
          rec.kind   = etok_pkg::K_END;
          rec.value  = 32'd0;
          rec.index  = 8'(te);
          rec.status = etok_pkg::ST_BADCHAR;
          rec.last   = 1'b1;
        end else if (te >= TOKEN_LIMIT) begin
          rec.index  = etok_pkg::IDX_DROPPED;
          rec.status = etok_pkg::ST_DROPPED;
        end else begin
          rec.index  = 8'(te);
          rec.status = etok_pkg::ST_OK;
          te         = te + 1'b1;
        end
        if (n < 3'(etok_pkg::SLOTS)) begin
          b.slot[n[etok_pkg::SLOT_W-1:0]] = rec;
          n = n + 3'd1;
        end
      end
    end
    if (end_tok && (n != 3'd0)) begin
      b.slot[etok_pkg::SLOT_W'(n - 3'd1)].last = 1'b1;
    end
    b.count      = n[etok_pkg::SLOT_W-1:0];
    bundle       = b;
    bundle_valid = (n != 3'd0);
    tokens_next  = te;
    mode_next    = m;

    if (end_of_text) begin
      mode_next   = etok_pkg::M_IDLE;
      acc_next    = 32'd0;
      dcount_next = '0;
      tokens_next = '0;
      bytes_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= etok_pkg::M_IDLE;
      acc    <= 32'd0;
      dcount <= '0;
      tokens <= '0;
      bytes  <= '0;
    end else if (fire) begin
      mode   <= mode_next;
      acc    <= acc_next;
      dcount <= dcount_next;
      tokens <= tokens_next;
      bytes  <= bytes_next;
    end
  end

endmodule

/* hw/rtl/etok_queue.sv */
module etok_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  etok_pkg::bundle_t wr_data,
  input  logic              rd,
  output etok_pkg::bundle_t rd_data,
  output logic              full,
  output logic              empty
);

  etok_pkg::bundle_t store [etok_pkg::QUEUE_DEPTH];
  logic [etok_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [etok_pkg::QCNT_W-1:0] fill;
  logic do_wr, do_rd;

  assign full    = (fill == etok_pkg::QCNT_W'(etok_pkg::QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) fill <= fill + 1'b1;
      else if (do_rd && !do_wr) fill <= fill - 1'b1;
    end
  end

endmodule

/* hw/rtl/etok_back.sv */
module etok_back (
  input  logic              clk,
  input  logic              rst,
  input  etok_pkg::bundle_t head,
  input  logic              head_empty,
  input  logic              pop,
  output logic              head_done,
  output etok_pkg::result_t result
);

  logic [etok_pkg::SLOT_W-1:0] sel, sel_next;
  logic take, at_end;

  // The slots of the oldest bundle go out one per pop.
  assign result    = head.slot[sel];
  assign take      = pop && !head_empty;
  assign at_end    = (sel == head.count - 1'b1);
  assign head_done = take && at_end;

  always_comb begin
    sel_next = sel;
    if (take) begin
      sel_next = at_end ? '0 : sel + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
    end else begin
      sel <= sel_next;
    end
  end

endmodule

/* hw/rtl/expression_tokenizer.sv */
// Channel   Direction  Handshake      Payload
// input     in         push / full    in_byte, end_of_text
// result    out        pop / empty    token_kind, number_value, token_index, status,
//                                     last_of_text
//
// One byte is taken per cycle; its 0 to 3 results are registered into the result-bundle
// queue and leave one per pop, so a byte with k results needs k pops.
// Input stalls only when the four-entry result-bundle queue is full.
// rst is synchronous and leaves the block idle with empty high and full low.
module expression_tokenizer #(
  parameter int MAX_TOKEN_COUNT   = etok_pkg::MAX_TOKEN_COUNT_DEF,
  parameter int MAX_TEXT_BYTES    = etok_pkg::MAX_TEXT_BYTES_DEF,
  parameter int MAX_NUMBER_DIGITS = etok_pkg::MAX_NUMBER_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  token_kind,
  output logic [31:0] number_value,
  output logic [7:0]  token_index,
  output logic [1:0]  status,
  output logic        last_of_text
);

  logic              fire, bundle_valid, head_done;
  etok_pkg::bundle_t bundle, head;
  etok_pkg::result_t result;

  assign fire = push && !full;

  etok_front #(
    .MAX_TOKEN_COUNT  (MAX_TOKEN_COUNT),
    .MAX_TEXT_BYTES   (MAX_TEXT_BYTES),
    .MAX_NUMBER_DIGITS(MAX_NUMBER_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .bundle_valid(bundle_valid),
    .bundle      (bundle)
  );

  etok_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (fire && bundle_valid),
    .wr_data(bundle),
    .rd     (head_done),
    .rd_data(head),
    .full   (full),
    .empty  (empty)
  );

  etok_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_empty(empty),
    .pop       (pop),
    .head_done (head_done),
    .result    (result)
  );

  assign token_kind   = result.kind;
  assign number_value = result.value;
  assign token_index  = result.index;
  assign status       = result.status;
  assign last_of_text = result.last;

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import etok_pkg::*;

  localparam int TOKEN_CAP  = MAX_TOKEN_COUNT_DEF;
  localparam int MAX_BYTES  = MAX_TEXT_BYTES_DEF;
  localparam int MAX_DIGITS = MAX_NUMBER_DIGITS_DEF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [4:0]  token_kind;
  logic [31:0] number_value;
  logic [7:0]  token_index;
  logic [1:0]  status;
  logic        last_of_text;

  expression_tokenizer u_top (
    .clk, .rst, .push, .full, .in_byte, .end_of_text, .empty, .pop,
    .token_kind, .number_value, .token_index, .status, .last_of_text
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int err_n = 0;
  int checked_n = 0;
  int live_n = 0;

  result_t    token_q[$];
  logic [7:0] text_q[$];

  string op_words[15] = '{"(", ")", "conc", "**", "<<", ">>", "+", "-", "~", "*", "/",
                          "%", "&", "|", "^"};

  // Lexer state mirrored from the byte stream.
  scan_mode_t  lx_mode;
  logic [31:0] lx_acc;
  int unsigned lx_digits;
  int unsigned lx_tokens;
  int unsigned lx_bytes;

  function automatic void lex_clear();
    lx_mode   = M_IDLE;
    lx_acc    = '0;
    lx_digits = 0;
    lx_tokens = 0;
    lx_bytes  = 0;
  endfunction

  function automatic void emit(token_kind_t k, logic [31:0] v, logic [7:0] idx, status_t st,
                               logic last);
    result_t r;
    r.kind   = k;
    r.value  = v;
    r.index  = idx;
    r.status = st;
    r.last   = last;
    token_q.push_back(r);
  endfunction

  function automatic void add_token(token_kind_t k, logic [31:0] v, logic last);
    if (lx_tokens >= TOKEN_CAP) begin
      emit(k, v, IDX_DROPPED, ST_DROPPED, last);
    end else begin
      emit(k, v, lx_tokens[7:0], ST_OK, last);
      lx_tokens++;
    end
  endfunction

  function automatic void lex_error();
    emit(K_END, '0, lx_tokens[7:0], ST_BADCHAR, 1'b1);
    lx_mode = M_SKIP;
  endfunction

  function automatic bit flush_pending();
    case (lx_mode)
      M_NUM: add_token(K_NUMBER, lx_acc, 1'b0);
      M_STAR: add_token(K_MUL, '0, 1'b0);
      M_LT, M_GT, M_C1, M_C2, M_C3: begin
        lex_error();
        return 1'b0;
      end
      default: ;
    endcase
    if (lx_mode != M_SKIP) lx_mode = M_IDLE;
    return 1'b1;
  endfunction

  function automatic void lex_char(logic [7:0] c);
    bit is_digit;
    is_digit = (c >= CH_DIG0) && (c <= CH_DIG9);
    case (lx_mode)
      M_C1: begin
        if (c == CH_LC_O) lx_mode = M_C2;
        else lex_error();
        return;
      end
      M_C2: begin
        if (c == CH_LC_N) lx_mode = M_C3;
        else lex_error();
        return;
      end
      M_C3: begin
        if (c == CH_LC_C) begin
          add_token(K_CONC, '0, 1'b0);
          lx_mode = M_IDLE;
        end else lex_error();
        return;
      end
      M_LT: begin
        if (c == CH_LT) begin
          add_token(K_LSHIFT, '0, 1'b0);
          lx_mode = M_IDLE;
        end else lex_error();
        return;
      end
      M_GT: begin
        if (c == CH_GT) begin
          add_token(K_RSHIFT, '0, 1'b0);
          lx_mode = M_IDLE;
        end else lex_error();
        return;
      end
      M_STAR: begin
        if (c == CH_STAR) begin
          add_token(K_POW, '0, 1'b0);
          lx_mode = M_IDLE;
          return;
        end
        add_token(K_MUL, '0, 1'b0);
        lx_mode = M_IDLE;
      end
      M_NUM: begin
        if (is_digit) begin
          // Digits past the limit are consumed but leave the value alone.
          if (lx_digits < MAX_DIGITS) begin
            lx_acc = lx_acc * 32'd10 + 32'(c - CH_DIG0);
            lx_digits++;
          end
          return;
        end
        add_token(K_NUMBER, lx_acc, 1'b0);
        lx_mode = M_IDLE;
      end
      M_IDLE: ;
      default: return;
    endcase

    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
    if (is_digit) begin
      lx_acc    = 32'(c - CH_DIG0);
      lx_digits = 1;
      lx_mode   = M_NUM;
      return;
    end
    case (c)
      CH_LPAREN: add_token(K_LPAREN, '0, 1'b0);
      CH_RPAREN: add_token(K_RPAREN, '0, 1'b0);
      CH_LC_C:   lx_mode = M_C1;
      CH_STAR:   lx_mode = M_STAR;
      CH_LT:     lx_mode = M_LT;
      CH_GT:     lx_mode = M_GT;
      CH_PLUS:   add_token(K_PLUS, '0, 1'b0);
      CH_MINUS:  add_token(K_MINUS, '0, 1'b0);
      CH_TILDE:  add_token(K_BITNOT, '0, 1'b0);
      CH_SLASH:  add_token(K_DIV, '0, 1'b0);
      CH_PCT:    add_token(K_MOD, '0, 1'b0);
      CH_AMP:    add_token(K_AND, '0, 1'b0);
      CH_BAR:    add_token(K_OR, '0, 1'b0);
      CH_CARET:  add_token(K_XOR, '0, 1'b0);
      default:   lex_error();
    endcase
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic eot);
    bit finish;
    finish = eot;
    if (lx_mode != M_SKIP && lx_bytes < MAX_BYTES) begin
      lx_bytes++;
      if (c == CH_NUL) finish = 1'b1;
      else lex_char(c);
    end
    if (finish && lx_mode != M_SKIP) begin
      // The END token closes the string even when it is itself dropped.
      if (flush_pending()) add_token(K_END, '0, 1'b1);
      lx_mode = M_SKIP;
    end
    if (eot) lex_clear();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_n++;
    if (err_n <= 40)
      $display("tb_top mismatch on %s: got %0d, want %0d (result %0d)", what, got, want,
               checked_n);
  endtask

  task automatic check_token();
    result_t want;
    if (token_q.size() == 0) begin
      report_mismatch("result with nothing waiting, kind", 32'(token_kind), 0);
    end else begin
      want = token_q.pop_front();
      if (token_kind !== want.kind) report_mismatch("token_kind", 32'(token_kind),
                                                    32'(want.kind));
      if (number_value !== want.value) report_mismatch("number_value", number_value,
                                                       want.value);
      if (token_index !== want.index) report_mismatch("token_index", 32'(token_index),
                                                      32'(want.index));
      if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
      if (last_of_text !== want.last) report_mismatch("last_of_text", 32'(last_of_text),
                                                      32'(want.last));
    end
    checked_n++;
  endtask

  // Result side: check what was taken at this edge, then decide on the next pop.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_token();
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_byte(logic [7:0] c, logic eot);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    in_byte     <= c;
    end_of_text <= eot;
    do @(posedge clk); while (full);
    if (lx_mode != M_SKIP && lx_bytes < MAX_BYTES) live_n++;
    lex_byte(c, eot);
  endtask

  function automatic void put_word(string w);
    for (int i = 0; i < w.len(); i++) text_q.push_back(w[i]);
  endfunction

  // Sends the collected text as one string, end_of_text on its last byte.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed_ops();
    put_word("(0+4294967295)-~7*1/2%3&4|5^6");
    send_text();
    // A star still pending at the end of the string becomes a multiply.
    put_word("**<<>>conc*");
    send_text();
    wait_drained();
  endtask

  task automatic test_error_cases();
    put_word("<");
    send_text();
    put_word("> 1");
    send_text();
    put_word("co)");
    send_text();
    put_word("1+@2");
    send_text();
    text_q.push_back(8'hFF);
    send_text();
    put_word("c");
    send_text();
    // A zero byte ends the string early; the rest is ignored.
    put_word("3");
    text_q.push_back(CH_NUL);
    put_word("+4");
    send_text();
    text_q.push_back(CH_NUL);
    send_text();
    for (int w = CH_TAB; w <= CH_CR; w++) text_q.push_back(8'(w));
    text_q.push_back(CH_SPACE);
    put_word("5*");
    send_text();
    wait_drained();
  endtask

  task automatic test_long_number();
    repeat (130) text_q.push_back(CH_DIG9);
    put_word("+1");
    send_text();
    wait_drained();
  endtask

  task automatic test_token_limit();
    repeat (258) text_q.push_back(CH_LPAREN);
    put_word("77");
    send_text();
    wait_drained();
  endtask

  task automatic test_text_limit();
    // Only 123 fits under the byte limit; the closing byte still ends the string.
    repeat (1020) text_q.push_back(CH_SPACE);
    put_word("12345)");
    send_text();
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    repeat (10) put_word("(1)+");
    put_word("2");
    send_text();
    wait_drained();
  endtask

  task automatic build_random_text();
    int n_pieces;
    int r;
    n_pieces = $urandom_range(1, 8);
    repeat (n_pieces) begin
      r = $urandom_range(99);
      if (r < 30) begin
        repeat ($urandom_range(1, 12)) text_q.push_back(8'(CH_DIG0 + $urandom_range(9)));
      end else if (r < 70) begin
        put_word(op_words[$urandom_range(14)]);
      end else if (r < 84) begin
        if ($urandom_range(1)) text_q.push_back(CH_SPACE);
        else text_q.push_back(8'($urandom_range(CH_TAB, CH_CR)));
      end else if (r < 92) begin
        case ($urandom_range(4))
          0: put_word("<");
          1: put_word(">");
          2: put_word("c");
          3: put_word("co");
          default: put_word("con");
        endcase
        text_q.push_back(8'($urandom_range(32, 126)));
      end else if (r < 98) begin
        text_q.push_back(8'($urandom_range(255)));
      end else begin
        text_q.push_back(CH_NUL);
      end
    end
  endtask

  task automatic test_random(int n_items);
    int target;
    target = live_n + n_items;
    while (live_n < target) begin
      build_random_text();
      send_text();
    end
    wait_drained();
  endtask

  initial begin
    lex_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 13;
    recv_idle = 84;
    test_directed_ops();
    test_error_cases();
    test_random(120);

    send_idle = 84;
    recv_idle = 13;
    test_long_number();
    test_random(120);

    send_idle = 0;
    recv_idle = 0;
    test_token_limit();
    test_text_limit();
    test_backpressure();
    test_random(120);

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_n == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
